// ===== design/dosc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dosc_pkg;

    // Field widths of the stream beats and of the register file.
    localparam int NODE_W     = 10;
    localparam int VALUE_W    = 32;
    localparam int COEF_W     = 31;
    localparam int DECAY_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int TDATA_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Node count of the default build and the span that the node index can address.
    localparam int NODES_DEFAULT = 1024;
    localparam int NODE_SPACE    = 1 << NODE_W;

    // Register values after reset.
    localparam logic [COEF_W-1:0]         STEP_RESET  = 31'd65;
    localparam logic [COEF_W-1:0]         INV_RESET   = 31'd1048576;
    localparam logic [COEF_W-1:0]         GAMMA_RESET = 31'd6553600;
    localparam logic [COEF_W-1:0]         TWO_RESET   = 31'd1311;
    localparam logic [DECAY_W-1:0]        DECAY_RESET = 17'd58982;
    localparam logic signed [VALUE_W-1:0] INIT_RESET  = 32'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        IX_STEP  = 3'd0,
        IX_INV   = 3'd1,
        IX_GAMMA = 3'd2,
        IX_TWO   = 3'd3,
        IX_DECAY = 3'd4,
        IX_INIT  = 3'd5
    } cfg_index_t;

    // Coefficients that the arithmetic pipeline reads.
    typedef struct packed {
        logic [COEF_W-1:0]  step_size;
        logic [COEF_W-1:0]  inverse_step;
        logic [COEF_W-1:0]  damping_rate;
        logic [COEF_W-1:0]  two_over_rate;
        logic [DECAY_W-1:0] decay_factor;
    } cfg_t;

    // One item as it enters the arithmetic pipeline, with the node state read back.
    typedef struct packed {
        logic [NODE_W-1:0]         node;
        logic                      in_range;
        logic signed [VALUE_W-1:0] drive;
        logic signed [VALUE_W-1:0] prev_drive;
        logic signed [VALUE_W-1:0] prev_field;
        logic signed [VALUE_W-1:0] field_rate;
    } entry_t;

    // State write-back of one finished item.
    typedef struct packed {
        logic                      en;
        logic [NODE_W-1:0]         node;
        logic signed [VALUE_W-1:0] drive;
        logic signed [VALUE_W-1:0] field;
        logic signed [VALUE_W-1:0] rate;
    } wb_t;

endpackage

`default_nettype wire

// ===== design/damped_oscillator_exact_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Critically damped second-order response per node, advanced by one exact time step for
// every drive beat, in signed Q16.16. Each input beat carries a node index and a new drive
// sample; the block reads that node's previous drive, field and field rate from an on-chip
// state memory, runs them through a twelve-stage arithmetic pipeline (one multiplier rank
// per stage pair), writes the new state back and returns the node index with the new
// saturated field value. Beats for different nodes are taken one per cycle while the
// result side does not stall. A beat whose node is still inside the pipeline waits until
// that earlier beat has written its state back. After reset, and after every write of
// the initial_level register, a clearing pass loads every node with the initial level
// and a zero rate; no beat is taken meanwhile. Registers are to be written through
// cfg_we, cfg_index and cfg_wdata only while the block is idle; the block itself does
// not enforce this. A node index not below NODES leaves all state alone and returns a
// zero field.
module damped_oscillator_exact_step #(
    parameter int NODES = dosc_pkg::NODES_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Input stream. s_tdata: node_index [9:0], drive_sample [41:10], zero [47:42].
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [dosc_pkg::TDATA_W-1:0]        s_tdata,
    // Result stream. m_tdata: node_out [9:0], field_value [41:10], zero [47:42].
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [dosc_pkg::TDATA_W-1:0]       m_tdata,
    // Register write port.
    input  wire                                cfg_we,
    input  wire [dosc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [dosc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dosc_pkg::*;

    // Only the nodes that the index can reach get a memory row.
    localparam int DEPTH  = (NODES < NODE_SPACE) ? NODES : NODE_SPACE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = 3 * VALUE_W;
    localparam int PAD_W  = TDATA_W - NODE_W - VALUE_W;
    localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(DEPTH - 1);

    // Register file.
    cfg_t                      cfg_reg;
    cfg_t                      cfg_next;
    logic signed [VALUE_W-1:0] init_level_reg;
    logic signed [VALUE_W-1:0] init_level_next;
    logic                      init_write;

    // Clearing pass.
    logic                      sweep_active_reg;
    logic                      sweep_active_next;
    logic [ADDR_W-1:0]         sweep_cnt_reg;
    logic [ADDR_W-1:0]         sweep_cnt_next;

    // Input side and first stage.
    logic [NODE_W-1:0]         s_node;
    logic signed [VALUE_W-1:0] s_drive;
    logic                      s_in_range;
    logic                      s_accept;
    logic                      s1_ready;
    logic                      hit;
    logic                      v1_reg;
    logic                      v1_next;
    logic [NODE_W-1:0]         node1_reg;
    logic                      in_range1_reg;
    logic signed [VALUE_W-1:0] drive1_reg;
    entry_t                    entry1;

    // State memory: drive in the low word, then field, then rate.
    logic [ROW_W-1:0]          mem [DEPTH];
    logic [ROW_W-1:0]          rd_row_reg;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ROW_W-1:0]          mem_wdata;

    // Pipeline connections.
    logic                      dp_in_ready;
    logic                      dp_hit;
    wb_t                       wb;
    logic [NODE_W-1:0]         dp_node;
    logic signed [VALUE_W-1:0] dp_field;

    // Register writes; a write of initial_level also restarts the clearing pass.
    always_comb begin
        cfg_next        = cfg_reg;
        init_level_next = init_level_reg;
        init_write      = 1'b0;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                IX_STEP:  cfg_next.step_size     = cfg_wdata[COEF_W-1:0];
                IX_INV:   cfg_next.inverse_step  = cfg_wdata[COEF_W-1:0];
                IX_GAMMA: cfg_next.damping_rate  = cfg_wdata[COEF_W-1:0];
                IX_TWO:   cfg_next.two_over_rate = cfg_wdata[COEF_W-1:0];
                IX_DECAY: cfg_next.decay_factor  = cfg_wdata[DECAY_W-1:0];
                IX_INIT: begin
                    init_level_next = cfg_wdata[VALUE_W-1:0];
                    init_write      = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sweep_active_next = sweep_active_reg;
        sweep_cnt_next    = sweep_cnt_reg;
        if (init_write) begin
            sweep_active_next = 1'b1;
            sweep_cnt_next    = '0;
        end else if (sweep_active_reg) begin
            if (sweep_cnt_reg == SWEEP_LAST) begin
                sweep_active_next = 1'b0;
            end else begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
            end
        end
    end

    // A beat is held off while its node is anywhere between the memory read and the
    // write-back, so every read sees the state that the previous beat left behind.
    always_comb begin
        s_node     = s_tdata[NODE_W-1:0];
        s_drive    = s_tdata[NODE_W+VALUE_W-1:NODE_W];
        s_in_range = 32'(s_node) < 32'(NODES);
        hit        = dp_hit || (v1_reg && in_range1_reg && (node1_reg == s_node));
        s1_ready   = !v1_reg || dp_in_ready;
        s_tready   = !sweep_active_reg && s1_ready && !hit;
        s_accept   = s_tvalid && s_tready;
        v1_next    = s1_ready ? s_accept : v1_reg;
    end

    always_comb begin
        entry1.node       = node1_reg;
        entry1.in_range   = in_range1_reg;
        entry1.drive      = drive1_reg;
        entry1.prev_drive = rd_row_reg[VALUE_W-1:0];
        entry1.prev_field = rd_row_reg[2*VALUE_W-1:VALUE_W];
        entry1.field_rate = rd_row_reg[3*VALUE_W-1:2*VALUE_W];
    end

    // The clearing pass owns the write port while it runs.
    always_comb begin
        mem_we = sweep_active_reg || wb.en;
        if (sweep_active_reg) begin
            mem_waddr = sweep_cnt_reg;
            mem_wdata = {{VALUE_W{1'b0}}, init_level_reg, init_level_reg};
        end else begin
            mem_waddr = wb.node[ADDR_W-1:0];
            mem_wdata = {wb.rate, wb.field, wb.drive};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_row_reg <= mem[s_node[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size     <= STEP_RESET;
            cfg_reg.inverse_step  <= INV_RESET;
            cfg_reg.damping_rate  <= GAMMA_RESET;
            cfg_reg.two_over_rate <= TWO_RESET;
            cfg_reg.decay_factor  <= DECAY_RESET;
            init_level_reg        <= INIT_RESET;
            sweep_active_reg      <= 1'b1;
            sweep_cnt_reg         <= '0;
            v1_reg                <= 1'b0;
        end else begin
            cfg_reg          <= cfg_next;
            init_level_reg   <= init_level_next;
            sweep_active_reg <= sweep_active_next;
            sweep_cnt_reg    <= sweep_cnt_next;
            v1_reg           <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            node1_reg     <= s_node;
            in_range1_reg <= s_in_range;
            drive1_reg    <= s_drive;
        end
    end

    dosc_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (v1_reg),
        .in_ready   (dp_in_ready),
        .in_entry   (entry1),
        .probe_node (s_node),
        .probe_hit  (dp_hit),
        .wb         (wb),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_node   (dp_node),
        .out_field  (dp_field)
    );

    assign m_tdata = {{PAD_W{1'b0}}, dp_field, dp_node};

`ifndef ASSERT_OFF
    // A beat is never taken in the cycle its node's state is being written back.
    a_no_stale_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && wb.en |-> (wb.node != s_node))
        else $error("beat accepted while its node is written back");

    // The clearing pass walks the memory one row per cycle.
    a_sweep_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_active_reg && (sweep_cnt_reg != SWEEP_LAST) && !init_write
        |=> sweep_active_reg && (sweep_cnt_reg == $past(sweep_cnt_reg) + 1'b1))
        else $error("clearing pass skipped or stopped early");

    // The clearing pass ends only after the last row.
    a_sweep_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(sweep_active_reg) |-> ($past(sweep_cnt_reg) == SWEEP_LAST))
        else $error("clearing pass ended before the last row");
`endif

endmodule

`default_nettype wire

// ===== design/dosc_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dosc_pipe (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire dosc_pkg::cfg_t                  cfg,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire dosc_pkg::entry_t                in_entry,
    input  wire [dosc_pkg::NODE_W-1:0]           probe_node,
    output logic                                 probe_hit,
    output dosc_pkg::wb_t                        wb,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [dosc_pkg::NODE_W-1:0]          out_node,
    output logic signed [dosc_pkg::VALUE_W-1:0]  out_field
);
    import dosc_pkg::*;

    localparam int FIRST   = 2;
    localparam int LAST    = 12;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int SHIFT_W = PROD_W - FRAC_W;

    typedef struct packed {
        logic [NODE_W-1:0]         node;
        logic                      in_range;
        logic signed [VALUE_W-1:0] q;
        logic signed [VALUE_W-1:0] pd;
        logic signed [VALUE_W-1:0] pf;
        logic signed [VALUE_W-1:0] fr;
        logic signed [VALUE_W-1:0] diff;
        logic signed [VALUE_W-1:0] slope;
        logic signed [VALUE_W-1:0] adj;
        logic signed [VALUE_W-1:0] c1;
        logic signed [VALUE_W-1:0] c12;
        logic signed [VALUE_W-1:0] field;
        logic signed [VALUE_W-1:0] t;
        logic signed [VALUE_W-1:0] rate;
        logic signed [SHIFT_W-1:0] ramp;
        logic signed [PROD_W-1:0]  p;
        logic signed [PROD_W-1:0]  p2;
    } pipe_t;

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Work of step k, which turns the contents of stage k into those of stage k+1.
    // A product shifted right arithmetically by the fraction width is its floor.
    function automatic pipe_t stage_work(input int k, input pipe_t s, input cfg_t c);
        pipe_t                     r;
        logic signed [VALUE_W-1:0] v;
        r = s;
        v = '0;
        case (k)
            1: r.diff = sat32(s.q - s.pd);
            2: r.p = s.diff * $signed({1'b0, c.inverse_step});
            3: begin
                v       = sat32($signed(s.p[PROD_W-1:FRAC_W]));
                r.slope = v;
                r.p     = $signed({1'b0, c.two_over_rate}) * v;
            end
            4: begin
                r.ramp = s.p[PROD_W-1:FRAC_W];
                r.adj  = sat32(s.pd - $signed(s.p[PROD_W-1:FRAC_W]) - s.pf);
            end
            5: r.p = $signed({1'b0, c.damping_rate}) * s.adj;
            6: r.c1 = sat32(s.fr - $signed(s.p[PROD_W-1:FRAC_W]) - s.slope);
            7: r.p = s.c1 * $signed({1'b0, c.step_size});
            8: r.c12 = sat32($signed(s.p[PROD_W-1:FRAC_W]) - s.adj);
            9: begin
                r.p  = s.c12 * $signed({1'b0, c.decay_factor});
                r.p2 = $signed({1'b0, c.damping_rate}) * s.c12;
            end
            10: begin
                r.field = sat32($signed(s.p[PROD_W-1:FRAC_W]) + s.q - s.ramp);
                r.t     = sat32(s.c1 - $signed(s.p2[PROD_W-1:FRAC_W]));
            end
            11: r.p = s.t * $signed({1'b0, c.decay_factor});
            12: begin
                r.rate = sat32($signed(s.p[PROD_W-1:FRAC_W]) + s.slope);
                if (!s.in_range) begin
                    r.field = '0;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    pipe_t                     in_pipe;
    pipe_t                     st_reg  [FIRST:LAST];
    pipe_t                     st_next [FIRST:LAST];
    logic                      v_reg   [FIRST:LAST];
    logic                      v_next  [FIRST:LAST];
    logic                      rdy     [FIRST:LAST];
    logic                      tail_ready;
    logic                      tail_move;
    pipe_t                     tail;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [NODE_W-1:0]         out_node_reg;
    logic signed [VALUE_W-1:0] out_field_reg;

    always_comb begin
        in_pipe          = '0;
        in_pipe.node     = in_entry.node;
        in_pipe.in_range = in_entry.in_range;
        in_pipe.q        = in_entry.drive;
        in_pipe.pd       = in_entry.prev_drive;
        in_pipe.pf       = in_entry.prev_field;
        in_pipe.fr       = in_entry.field_rate;
    end

    // A stage takes new contents when it is empty or its contents move on.
    always_comb begin
        tail_ready = !out_valid_reg || out_ready;
        rdy[LAST]  = !v_reg[LAST] || tail_ready;
        for (int k = LAST - 1; k >= FIRST; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[FIRST];

    always_comb begin
        st_next[FIRST] = st_reg[FIRST];
        v_next[FIRST]  = v_reg[FIRST];
        if (rdy[FIRST]) begin
            st_next[FIRST] = stage_work(1, in_pipe, cfg);
            v_next[FIRST]  = in_valid;
        end
        for (int k = FIRST + 1; k <= LAST; k++) begin
            st_next[k] = st_reg[k];
            v_next[k]  = v_reg[k];
            if (rdy[k]) begin
                st_next[k] = stage_work(k - 1, st_reg[k-1], cfg);
                v_next[k]  = v_reg[k-1];
            end
        end
    end

    always_comb begin
        tail           = stage_work(LAST, st_reg[LAST], cfg);
        tail_move      = v_reg[LAST] && tail_ready;
        out_valid_next = tail_ready ? v_reg[LAST] : out_valid_reg;
        wb.en          = tail_move && st_reg[LAST].in_range;
        wb.node        = st_reg[LAST].node;
        wb.drive       = st_reg[LAST].q;
        wb.field       = tail.field;
        wb.rate        = tail.rate;
    end

    always_comb begin
        probe_hit = 1'b0;
        for (int k = FIRST; k <= LAST; k++) begin
            if (v_reg[k] && st_reg[k].in_range && (st_reg[k].node == probe_node)) begin
                probe_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = FIRST; k <= LAST; k++) begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else begin
            for (int k = FIRST; k <= LAST; k++) begin
                v_reg[k] <= v_next[k];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = FIRST; k <= LAST; k++) begin
            st_reg[k] <= st_next[k];
        end
        if (tail_ready) begin
            out_node_reg  <= st_reg[LAST].node;
            out_field_reg <= tail.field;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_field = out_field_reg;

endmodule

`default_nettype wire

// ===== tb/sv/damped_oscillator_exact_step_tb.sv =====
`timescale 1ns / 1ps

module damped_oscillator_exact_step_tb;
    import dosc_pkg::*;

    // Run limits. The cycle limit leaves a wide margin over the slowest correct run.
    // PIPE_SETTLE covers the twelve-stage pipeline.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PIPE_SETTLE  = 16;
    localparam int REPORT_LIMIT = 10;

    // Register indexes past the end of the register file. Writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] IX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IX_SPARE_HI = 3'd7;

    // One expected result beat.
    typedef struct {
        logic [NODE_W-1:0]         node;
        logic signed [VALUE_W-1:0] field;
    } field_result_t;

    // Tracks the register file and the per-node oscillator state, predicts the field
    // value of every accepted drive beat, and checks result beats in order.
    class field_scoreboard;
        longint dt_q, inv_dt_q, gamma_q, two_by_gamma_q, decay_q, start_level;
        longint held_drive [NODE_SPACE];
        longint held_field [NODE_SPACE];
        longint held_rate  [NODE_SPACE];
        field_result_t expected_fields[$];
        int mismatches;

        function new();
            dt_q           = longint'(STEP_RESET);
            inv_dt_q       = longint'(INV_RESET);
            gamma_q        = longint'(GAMMA_RESET);
            two_by_gamma_q = longint'(TWO_RESET);
            decay_q        = longint'(DECAY_RESET);
            start_level    = longint'(INIT_RESET);
            mismatches     = 0;
            reload_nodes();
        endfunction

        function void reload_nodes();
            for (int i = 0; i < NODE_SPACE; i++) begin
                held_drive[i] = start_level;
                held_field[i] = start_level;
                held_rate[i]  = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                IX_STEP:  dt_q           = longint'(value[COEF_W-1:0]);
                IX_INV:   inv_dt_q       = longint'(value[COEF_W-1:0]);
                IX_GAMMA: gamma_q        = longint'(value[COEF_W-1:0]);
                IX_TWO:   two_by_gamma_q = longint'(value[COEF_W-1:0]);
                IX_DECAY: decay_q        = longint'(value[DECAY_W-1:0]);
                IX_INIT: begin
                    start_level = longint'($signed(value));
                    reload_nodes();
                end
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        // Q16.16 product, rounded toward minus infinity.
        function longint qmul(longint a, longint b);
            return (a * b) >>> FRAC_W;
        endfunction

        function void predict_field(logic [NODE_W-1:0] node, logic signed [VALUE_W-1:0] drive);
            field_result_t res;
            longint q, diff, slope, ramp, adj, c1, c12, fld, rt;
            int n;
            n = int'(node);
            q = longint'(drive);
            res.node = node;
            if (n >= NODES_DEFAULT) begin
                res.field = '0;
                expected_fields.push_back(res);
                return;
            end
            diff  = clamp32(q - held_drive[n]);
            slope = clamp32(qmul(diff, inv_dt_q));
            ramp  = qmul(two_by_gamma_q, slope);
            adj   = clamp32(held_drive[n] - ramp - held_field[n]);
            c1    = clamp32(held_rate[n] - qmul(gamma_q, adj) - slope);
            c12   = clamp32(qmul(c1, dt_q) - adj);
            fld   = clamp32(qmul(c12, decay_q) + q - ramp);
            rt    = clamp32(qmul(clamp32(c1 - qmul(gamma_q, c12)), decay_q) + slope);
            held_drive[n] = q;
            held_field[n] = fld;
            held_rate[n]  = rt;
            res.field = fld[VALUE_W-1:0];
            expected_fields.push_back(res);
        endfunction

        function void check_field(logic [NODE_W-1:0] node, logic signed [VALUE_W-1:0] field);
            field_result_t want;
            if (expected_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result beat, node %0d field %0d",
                             $time, node, field);
                return;
            end
            want = expected_fields.pop_front();
            if (want.node !== node || want.field !== field) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: expected node %0d field %0d, got node %0d field %0d",
                             $time, want.node, want.field, node, field);
            end
        endfunction

        function bit drained();
            return expected_fields.size() == 0;
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [TDATA_W-1:0]     m_tdata;

    field_scoreboard board;
    int cycle_count = 0;

    // Stimulus shaping: when the sender is calm it never leaves gaps; the node pool
    // keeps most beats on a few nodes so that back-to-back updates of one node hit
    // the pipeline hazard; the last drive sent to each node lets the random part
    // send smooth drive sequences.
    bit                 sender_calm = 1'b0;
    logic [NODE_W-1:0]  node_pool [4];
    logic signed [31:0] last_sent [NODE_SPACE];

    // Receiver state: a mode that changes now and then, and a counter for long stalls.
    int ready_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    int ready_roll;

    damped_oscillator_exact_step dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Safety net: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("damped_oscillator_exact_step_tb: done, errors");
            $finish;
        end
    end

    // Result side. Every accepted result beat is checked against the oldest prediction.
    // The ready line runs in one of three modes: always ready, light stalls with an
    // occasional long stall, or heavy stalls.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_field(m_tdata[NODE_W-1:0], m_tdata[NODE_W +: VALUE_W]);

        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end

        ready_roll = $urandom_range(0, 99);
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: begin
                    m_tready <= (ready_roll >= 20);
                    if (ready_roll < 2)
                        hold_left <= $urandom_range(15, 60);
                end
                default: m_tready <= (ready_roll >= 60);
            endcase
        end
    end

    // Gap before the next beat: mostly none or short, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Sends one drive beat after an optional gap and records it once accepted.
    // The valid line stays high after the beat so that a following beat with no
    // gap needs only one assignment in its time step.
    task automatic send_drive(input logic [NODE_W-1:0] node,
                              input logic signed [VALUE_W-1:0] drive, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - NODE_W - VALUE_W){1'b0}}, drive, node};
        do @(posedge aclk); while (!s_tready);
        board.predict_field(node, drive);
        last_sent[node] = drive;
    endtask

    // Holds the sender until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (!board.drained());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.set_reg(idx, value);
    endtask

    // Reprograms the whole register file with the block idle. The initial level goes
    // last, since writing it starts the clearing pass over all nodes. The spare
    // indexes get random data that the block has to ignore.
    task automatic program_regs(input logic [31:0] step, input logic [31:0] inv,
                                input logic [31:0] gam, input logic [31:0] two,
                                input logic [31:0] decay, input logic [31:0] level);
        drain_results();
        repeat (PIPE_SETTLE) @(posedge aclk);
        write_reg(IX_STEP, step);
        write_reg(IX_INV, inv);
        write_reg(IX_GAMMA, gam);
        write_reg(IX_TWO, two);
        write_reg(IX_DECAY, decay);
        write_reg(IX_SPARE_LO, $urandom());
        write_reg(IX_SPARE_HI, $urandom());
        write_reg(IX_INIT, level);
        cfg_we <= 1'b0;
    endtask

    // Physically consistent coefficients: dt between about 0.0005 and 0.05, gamma
    // between 5 and 500, with 1/dt, 2/gamma and exp(-gamma*dt) derived from them.
    // A decay_mode of 1 forces a decay of exactly one, 2 forces one above one.
    task automatic program_physical(input int decay_mode);
        int step_i;
        real gam_r;
        logic [31:0] decay;
        step_i = $urandom_range(33, 3277);
        gam_r  = $urandom_range(5, 499) + $urandom_range(0, 999) / 1000.0;
        case (decay_mode)
            1: decay = 32'd65536;
            2: decay = $urandom_range(65537, 131071);
            default: decay = $rtoi($exp(-gam_r * step_i / 65536.0) * 65536.0);
        endcase
        program_regs(step_i, $rtoi(65536.0 * 65536.0 / step_i), $rtoi(gam_r * 65536.0),
                     $rtoi(2.0 / gam_r * 65536.0), decay,
                     int'($urandom_range(0, 100 * 65536)) - 50 * 65536);
    endtask

    function automatic logic [NODE_W-1:0] pick_node();
        if ($urandom_range(0, 99) < 65)
            return node_pool[$urandom_range(0, 3)];
        return NODE_W'($urandom_range(0, NODE_SPACE - 1));
    endfunction

    // Drive content: mostly smooth steps from the node's last drive, then fresh
    // moderate values, and a few full-range values and extremes.
    function automatic logic signed [31:0] pick_drive(input logic [NODE_W-1:0] node);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return last_sent[node] + int'($urandom_range(0, 4 * 65536)) - 2 * 65536;
        if (r < 92)
            return int'($urandom_range(0, 200 * 65536)) - 100 * 65536;
        if (r < 97)
            return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic random_beats(input int count);
        logic [NODE_W-1:0] node;
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                sender_calm = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < 4; k++)
                    node_pool[k] = NODE_W'($urandom_range(0, NODE_SPACE - 1));
            end
            // Now and then the sender waits for the block to run dry.
            if ($urandom_range(0, 149) == 0)
                drain_results();
            node = pick_node();
            send_drive(node, pick_drive(node), pick_gap());
        end
    endtask

    initial begin
        board = new();
        for (int i = 0; i < NODE_SPACE; i++)
            last_sent[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats with the reset coefficients, back to back: drive extremes,
        // both ends of the node range, alternating bit patterns, and runs on one node
        // and on two interleaved nodes to hit the pipeline hazard.
        send_drive(10'd0, 32'h0000_0000, 0);
        send_drive(10'd0, 32'h7FFF_FFFF, 0);
        send_drive(10'd0, 32'h8000_0000, 0);
        send_drive(10'd0, 32'hFFFF_FFFF, 0);
        send_drive(10'd0, 32'h0000_0001, 0);
        repeat (4) send_drive(10'd5, 32'h0001_0000, 0);
        send_drive(10'd1023, 32'h7FFF_FFFF, 0);
        send_drive(10'd1023, 32'h8000_0000, 0);
        send_drive(10'd1023, 32'h0001_0000, 0);
        send_drive(10'h155, 32'h5555_5555, 0);
        send_drive(10'h2AA, 32'hAAAA_AAAA, 0);
        send_drive(10'd1, 32'hFFFF_0000, 0);
        send_drive(10'd2, 32'h0003_0000, 0);
        send_drive(10'd3, 32'hFFFD_0000, 0);
        send_drive(10'd2, 32'h0000_8000, 0);
        send_drive(10'd3, 32'hFFFF_8000, 0);
        send_drive(10'd1, 32'h0000_0000, 0);

        // Register settings in turn: physical ones, every register at its top value
        // (upper write bits set to check that they are dropped), every register at
        // zero with the lowest initial level, and decay at and above one.
        for (int phase = 0; phase < 9; phase++) begin
            case (phase)
                1: begin
                    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
                    random_beats(60);
                end
                2: begin
                    program_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
                    random_beats(60);
                end
                default: begin
                    program_physical(phase == 4 ? 1 : (phase == 6 ? 2 : 0));
                    random_beats(220);
                end
            endcase
        end

        drain_results();
        repeat (PIPE_SETTLE) @(posedge aclk);
        if (board.mismatches == 0)
            $display("damped_oscillator_exact_step_tb: done, clean");
        else
            $display("damped_oscillator_exact_step_tb: done, errors");
        $finish;
    end

endmodule
